>>> hdl/hfs_pkg.sv
`default_nettype none

package hfs_pkg;

    localparam int CFG_INDEX_W = 3;
    localparam int CFG_DATA_W  = 32;

    typedef enum logic [2:0] {
        OP_WATER    = 3'd0,
        OP_BODY     = 3'd1,
        OP_POWER    = 3'd2,
        OP_RESTART  = 3'd3,
        OP_EXTERNAL = 3'd4
    } op_t;

    typedef logic [3:0] fault_t;

    localparam fault_t FAULT_NONE        = 4'd0;
    localparam fault_t FAULT_WATER_LOST  = 4'd1;
    localparam fault_t FAULT_OVERTEMP    = 4'd2;
    localparam fault_t FAULT_BODY_TEMP   = 4'd3;
    localparam fault_t FAULT_RELAY_STUCK = 4'd4;
    localparam fault_t FAULT_BODY_LOST   = 4'd5;
    localparam fault_t FAULT_ELEMENT     = 4'd6;
    localparam fault_t FAULT_OVERCURRENT = 4'd7;
    localparam fault_t FAULT_MAX_CODE    = 4'd10;

    localparam logic [CFG_INDEX_W-1:0] CFG_WATER_FAULT_TEMP = 3'd0;
    localparam logic [CFG_INDEX_W-1:0] CFG_BODY_FAULT_TEMP  = 3'd1;
    localparam logic [CFG_INDEX_W-1:0] CFG_WATER_LOST_MS    = 3'd2;
    localparam logic [CFG_INDEX_W-1:0] CFG_BODY_LOST_MS     = 3'd3;
    localparam logic [CFG_INDEX_W-1:0] CFG_ELEMENT_CHECK_MS = 3'd4;
    localparam logic [CFG_INDEX_W-1:0] CFG_MIN_POWER_W      = 3'd5;
    localparam logic [CFG_INDEX_W-1:0] CFG_MAX_POWER_W      = 3'd6;
    localparam logic [CFG_INDEX_W-1:0] CFG_STUCK_POWER_W    = 3'd7;

    localparam logic signed [15:0] WATER_FAULT_TEMP_RST = 16'sd1360;
    localparam logic signed [15:0] BODY_FAULT_TEMP_RST  = 16'sd1120;
    localparam logic [31:0]        WATER_LOST_MS_RST    = 32'd10000;
    localparam logic [31:0]        BODY_LOST_MS_RST     = 32'd10000;
    localparam logic [31:0]        ELEMENT_CHECK_MS_RST = 32'd5000;
    localparam logic [15:0]        MIN_POWER_W_RST      = 16'd500;
    localparam logic [15:0]        MAX_POWER_W_RST      = 16'd3000;
    localparam logic [15:0]        STUCK_POWER_W_RST    = 16'd100;

    localparam logic [31:0] STUCK_DELAY_MS = 32'd3000;

endpackage

`default_nettype wire

>>> hdl/heater_fault_supervisor.sv
`default_nettype none

// Channel   Handshake               Payload
// input     in_valid / in_stall     operation, now_ms, temp_value, temp_missing,
//                                   power_watts, power_valid, relay_on, external_code
// output    out_valid / out_stall   fault_code, new_fault
// config    cfg_we                  cfg_index, cfg_data
//
// One event per cycle unless stalled; each event passes the input and result registers.
// It is evaluated combinationally from the input register against the tracker state,
// and the state and the result register are written at the same edge.
// Reset clears the latched fault and all timers and loads the threshold defaults.
// A stall on the output holds the result register and then the input register.
module heater_fault_supervisor (
    input  wire logic                            clk,
    input  wire logic                            rst_n,
    input  wire logic                            in_valid,
    output      logic                            in_stall,
    input  wire logic [2:0]                      operation,
    input  wire logic [31:0]                     now_ms,
    input  wire logic signed [15:0]              temp_value,
    input  wire logic                            temp_missing,
    input  wire logic [15:0]                     power_watts,
    input  wire logic                            power_valid,
    input  wire logic                            relay_on,
    input  wire logic [3:0]                      external_code,
    output      logic                            out_valid,
    input  wire logic                            out_stall,
    output      logic [3:0]                      fault_code,
    output      logic                            new_fault,
    input  wire logic                            cfg_we,
    input  wire logic [hfs_pkg::CFG_INDEX_W-1:0] cfg_index,
    input  wire logic [hfs_pkg::CFG_DATA_W-1:0]  cfg_data
);
    import hfs_pkg::*;

    // Configuration registers
    logic signed [15:0] water_fault_temp_reg;
    logic signed [15:0] body_fault_temp_reg;
    logic [31:0]        water_lost_ms_reg;
    logic [31:0]        body_lost_ms_reg;
    logic [31:0]        element_check_ms_reg;
    logic [15:0]        min_power_w_reg;
    logic [15:0]        max_power_w_reg;
    logic [15:0]        stuck_power_w_reg;

    // Input register
    logic               s1_valid_reg;
    logic [2:0]         op_reg;
    logic [31:0]        now_reg;
    logic signed [15:0] temp_reg;
    logic               missing_reg;
    logic [15:0]        power_reg;
    logic               pvalid_reg;
    logic               relay_reg;
    logic [3:0]         ext_reg;

    // Tracker state
    fault_t      latched_reg, latched_next;
    logic [31:0] water_since_reg, water_since_next;
    logic        water_seen_reg, water_seen_next;
    logic [31:0] body_since_reg, body_since_next;
    logic        body_seen_reg, body_seen_next;
    logic        body_ever_reg, body_ever_next;
    logic [31:0] off_since_reg, off_since_next;
    logic        was_on_reg, was_on_next;
    logic [31:0] on_since_reg, on_since_next;
    logic        on_tracked_reg, on_tracked_next;

    // Result register
    logic        out_valid_reg;
    fault_t      fault_code_reg;
    logic        new_fault_reg, new_fault_next;

    logic        advance;
    logic        fire;
    logic        faulted;
    fault_t      cand;
    logic [31:0] on_ref;
    logic [31:0] off_ref;

    assign advance  = !out_valid_reg || !out_stall;
    assign in_stall = s1_valid_reg && !advance;
    assign fire     = s1_valid_reg && advance;
    assign faulted  = latched_reg != FAULT_NONE;

    assign out_valid  = out_valid_reg;
    assign fault_code = fault_code_reg;
    assign new_fault  = new_fault_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            water_fault_temp_reg <= WATER_FAULT_TEMP_RST;
            body_fault_temp_reg  <= BODY_FAULT_TEMP_RST;
            water_lost_ms_reg    <= WATER_LOST_MS_RST;
            body_lost_ms_reg     <= BODY_LOST_MS_RST;
            element_check_ms_reg <= ELEMENT_CHECK_MS_RST;
            min_power_w_reg      <= MIN_POWER_W_RST;
            max_power_w_reg      <= MAX_POWER_W_RST;
            stuck_power_w_reg    <= STUCK_POWER_W_RST;
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                CFG_WATER_FAULT_TEMP: water_fault_temp_reg <= signed'(cfg_data[15:0]);
                CFG_BODY_FAULT_TEMP:  body_fault_temp_reg  <= signed'(cfg_data[15:0]);
                CFG_WATER_LOST_MS:    water_lost_ms_reg    <= cfg_data;
                CFG_BODY_LOST_MS:     body_lost_ms_reg     <= cfg_data;
                CFG_ELEMENT_CHECK_MS: element_check_ms_reg <= cfg_data;
                CFG_MIN_POWER_W:      min_power_w_reg      <= cfg_data[15:0];
                CFG_MAX_POWER_W:      max_power_w_reg      <= cfg_data[15:0];
                CFG_STUCK_POWER_W:    stuck_power_w_reg    <= cfg_data[15:0];
                default:              ;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg <= 1'b0;
        end
        else if (!in_stall)
        begin
            s1_valid_reg <= in_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_valid && !in_stall)
        begin
            op_reg      <= operation;
            now_reg     <= now_ms;
            temp_reg    <= temp_value;
            missing_reg <= temp_missing;
            power_reg   <= power_watts;
            pvalid_reg  <= power_valid;
            relay_reg   <= relay_on;
            ext_reg     <= external_code;
        end
    end

    // An unseen relay-on edge uses the current time as its start, and a relay
    // that was on until now restarts the off timer at the current time.
    assign on_ref  = on_tracked_reg ? on_since_reg : now_reg;
    assign off_ref = was_on_reg ? now_reg : off_since_reg;

    always_comb
    begin
        water_since_next = water_since_reg;
        water_seen_next  = water_seen_reg;
        body_since_next  = body_since_reg;
        body_seen_next   = body_seen_reg;
        body_ever_next   = body_ever_reg;
        off_since_next   = off_since_reg;
        was_on_next      = was_on_reg;
        on_since_next    = on_since_reg;
        on_tracked_next  = on_tracked_reg;
        cand             = FAULT_NONE;

        case (op_t'(op_reg))
            OP_WATER:
            begin
                if (!faulted)
                begin
                    if (missing_reg)
                    begin
                        if (water_seen_reg)
                        begin
                            water_since_next = now_reg;
                            water_seen_next  = 1'b0;
                        end
                        else if (now_reg - water_since_reg >= water_lost_ms_reg)
                        begin
                            cand = FAULT_WATER_LOST;
                        end
                    end
                    else
                    begin
                        water_seen_next = 1'b1;
                        if (temp_reg >= water_fault_temp_reg)
                        begin
                            cand = FAULT_OVERTEMP;
                        end
                    end
                end
            end
            OP_BODY:
            begin
                if (!faulted)
                begin
                    if (!missing_reg && temp_reg >= body_fault_temp_reg)
                    begin
                        cand = FAULT_BODY_TEMP;
                    end
                    else if (missing_reg)
                    begin
                        if (body_seen_reg)
                        begin
                            body_since_next = now_reg;
                            body_seen_next  = 1'b0;
                        end
                        else if (body_ever_reg &&
                                 now_reg - body_since_reg >= body_lost_ms_reg)
                        begin
                            cand = FAULT_BODY_LOST;
                        end
                    end
                    else
                    begin
                        body_seen_next = 1'b1;
                        body_ever_next = 1'b1;
                    end
                end
            end
            OP_POWER:
            begin
                if (!faulted)
                begin
                    if (relay_reg)
                    begin
                        was_on_next     = 1'b1;
                        on_since_next   = on_ref;
                        on_tracked_next = 1'b1;
                        if (pvalid_reg && now_reg - on_ref >= element_check_ms_reg)
                        begin
                            // Element fault takes priority when both limits trip.
                            if (power_reg < min_power_w_reg)
                            begin
                                cand = FAULT_ELEMENT;
                            end
                            else if (power_reg > max_power_w_reg)
                            begin
                                cand = FAULT_OVERCURRENT;
                            end
                        end
                    end
                    else
                    begin
                        on_tracked_next = 1'b0;
                        off_since_next  = off_ref;
                        was_on_next     = 1'b0;
                        if (pvalid_reg && now_reg - off_ref >= STUCK_DELAY_MS &&
                            power_reg >= stuck_power_w_reg)
                        begin
                            cand = FAULT_RELAY_STUCK;
                        end
                    end
                end
            end
            OP_RESTART:
            begin
                water_since_next = now_reg;
                water_seen_next  = 1'b0;
                body_since_next  = now_reg;
                body_seen_next   = 1'b0;
                body_ever_next   = 1'b0;
                off_since_next   = now_reg;
                was_on_next      = 1'b0;
                on_since_next    = now_reg;
                on_tracked_next  = 1'b0;
            end
            OP_EXTERNAL:
            begin
                if (ext_reg != FAULT_NONE && ext_reg <= FAULT_MAX_CODE)
                begin
                    cand = ext_reg;
                end
            end
            default:
            begin
            end
        endcase

        new_fault_next = !faulted && cand != FAULT_NONE;
        latched_next   = new_fault_next ? cand : latched_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            latched_reg     <= FAULT_NONE;
            water_since_reg <= '0;
            water_seen_reg  <= 1'b0;
            body_since_reg  <= '0;
            body_seen_reg   <= 1'b0;
            body_ever_reg   <= 1'b0;
            off_since_reg   <= '0;
            was_on_reg      <= 1'b0;
            on_since_reg    <= '0;
            on_tracked_reg  <= 1'b0;
        end
        else if (fire)
        begin
            latched_reg     <= latched_next;
            water_since_reg <= water_since_next;
            water_seen_reg  <= water_seen_next;
            body_since_reg  <= body_since_next;
            body_seen_reg   <= body_seen_next;
            body_ever_reg   <= body_ever_next;
            off_since_reg   <= off_since_next;
            was_on_reg      <= was_on_next;
            on_since_reg    <= on_since_next;
            on_tracked_reg  <= on_tracked_next;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (advance)
        begin
            out_valid_reg <= s1_valid_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (fire)
        begin
            fault_code_reg <= latched_next;
            new_fault_reg  <= new_fault_next;
        end
    end

    // A reported new fault always carries a real fault code.
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && new_fault |-> fault_code != FAULT_NONE)
        else $error("new fault reported with no fault code");

    // Once latched, the fault never changes until reset.
    assert property (@(posedge clk) disable iff (!rst_n)
        latched_reg != FAULT_NONE |=> latched_reg == $past(latched_reg))
        else $error("latched fault changed");

    // The input side only stalls when an event is held in the input register.
    assert property (@(posedge clk) disable iff (!rst_n)
        in_stall |-> s1_valid_reg && out_valid_reg && out_stall)
        else $error("input stalled with no held event");

    // An event processed while a fault is latched never reports a new fault.
    assert property (@(posedge clk) disable iff (!rst_n)
        fire && faulted |=> !new_fault_reg)
        else $error("second fault latched");

endmodule

`default_nettype wire

>>> verif/tb.sv
`timescale 1ns / 100ps

module tb;

    import hfs_pkg::*;

    localparam int CYCLE_LIMIT = 200000;
    localparam int IDLE_PCT    = 28;

    typedef struct packed {
        logic [2:0]  op;
        logic [31:0] now;
        logic [15:0] temp;
        logic        missing;
        logic [15:0] watts;
        logic        pvalid;
        logic        relay;
        logic [3:0]  ext;
    } heat_evt_t;

    typedef struct packed {
        logic [15:0] water_limit;
        logic [15:0] body_limit;
        logic [31:0] water_lost;
        logic [31:0] body_lost;
        logic [31:0] element_delay;
        logic [15:0] min_w;
        logic [15:0] max_w;
        logic [15:0] stuck_w;
    } limits_t;

    typedef struct packed {
        fault_t      fault;
        logic [31:0] water_miss_t;
        logic        water_ok;
        logic [31:0] body_miss_t;
        logic        body_ok;
        logic        body_seen;
        logic [31:0] off_t;
        logic        was_on;
        logic [31:0] on_t;
        logic        on_tracked;
    } tracker_t;

    typedef struct packed {
        fault_t code;
        logic   fresh;
    } verdict_t;

    logic                   clk = 1'b0;
    logic                   rst_n = 1'b0;
    logic                   in_valid = 1'b0;
    logic                   in_stall;
    logic [2:0]             operation = '0;
    logic [31:0]            now_ms = '0;
    logic [15:0]            temp_value = '0;
    logic                   temp_missing = 1'b0;
    logic [15:0]            power_watts = '0;
    logic                   power_valid = 1'b0;
    logic                   relay_on = 1'b0;
    logic [3:0]             external_code = '0;
    logic                   out_valid;
    logic                   out_stall = 1'b0;
    logic [3:0]             fault_code;
    logic                   new_fault;
    logic                   cfg_we = 1'b0;
    logic [CFG_INDEX_W-1:0] cfg_index = '0;
    logic [CFG_DATA_W-1:0]  cfg_data = '0;

    heat_evt_t   event_backlog[$];
    verdict_t    fault_reports[$];
    limits_t     lim;
    tracker_t    live;
    tracker_t    plan;
    logic [31:0] plan_now;
    logic        plan_relay;
    op_t         aim = OP_WATER;
    fault_t      latched_code = FAULT_NONE;
    int          staged = 0;
    int          sent = 0;
    int          seen = 0;
    int          fails = 0;
    int          settings = 0;
    int          hold_left = 0;
    bit          hold_done = 1'b0;
    int unsigned cycles = 0;

    heater_fault_supervisor dut (
        .clk           (clk),
        .rst_n         (rst_n),
        .in_valid      (in_valid),
        .in_stall      (in_stall),
        .operation     (operation),
        .now_ms        (now_ms),
        .temp_value    (temp_value),
        .temp_missing  (temp_missing),
        .power_watts   (power_watts),
        .power_valid   (power_valid),
        .relay_on      (relay_on),
        .external_code (external_code),
        .out_valid     (out_valid),
        .out_stall     (out_stall),
        .fault_code    (fault_code),
        .new_fault     (new_fault),
        .cfg_we        (cfg_we),
        .cfg_index     (cfg_index),
        .cfg_data      (cfg_data)
    );

    always
    begin
        #6 clk = 1'b1;
        #6 clk = 1'b0;
    end

    // Advances the supervisor state by one event and reports whether it latched.
    function automatic void supervise(inout tracker_t st, input limits_t lm,
                                      input heat_evt_t ev, output logic raised);
        fault_t      hit;
        fault_t      keep;
        logic [31:0] gap;
        hit = FAULT_NONE;
        raised = 1'b0;
        case (ev.op)
            OP_WATER:
                if (st.fault == FAULT_NONE)
                begin
                    if (ev.missing)
                    begin
                        gap = ev.now - st.water_miss_t;
                        if (st.water_ok)
                        begin
                            st.water_miss_t = ev.now;
                            st.water_ok = 1'b0;
                        end
                        else if (gap >= lm.water_lost)
                            hit = FAULT_WATER_LOST;
                    end
                    else
                    begin
                        st.water_ok = 1'b1;
                        if ($signed(ev.temp) >= $signed(lm.water_limit))
                            hit = FAULT_OVERTEMP;
                    end
                end
            OP_BODY:
                if (st.fault == FAULT_NONE)
                begin
                    gap = ev.now - st.body_miss_t;
                    if (!ev.missing && $signed(ev.temp) >= $signed(lm.body_limit))
                        hit = FAULT_BODY_TEMP;
                    else if (ev.missing)
                    begin
                        if (st.body_ok)
                        begin
                            st.body_miss_t = ev.now;
                            st.body_ok = 1'b0;
                        end
                        // A body sensor that never reported is not treated as lost.
                        else if (st.body_seen && gap >= lm.body_lost)
                            hit = FAULT_BODY_LOST;
                    end
                    else
                    begin
                        st.body_ok = 1'b1;
                        st.body_seen = 1'b1;
                    end
                end
            OP_POWER:
                if (st.fault == FAULT_NONE)
                begin
                    if (ev.relay)
                    begin
                        st.was_on = 1'b1;
                        if (!st.on_tracked)
                        begin
                            st.on_t = ev.now;
                            st.on_tracked = 1'b1;
                        end
                        gap = ev.now - st.on_t;
                        if (ev.pvalid && gap >= lm.element_delay)
                        begin
                            // With crossed limits the element fault takes priority.
                            if (ev.watts < lm.min_w)
                                hit = FAULT_ELEMENT;
                            else if (ev.watts > lm.max_w)
                                hit = FAULT_OVERCURRENT;
                        end
                    end
                    else
                    begin
                        st.on_tracked = 1'b0;
                        if (st.was_on)
                        begin
                            st.off_t = ev.now;
                            st.was_on = 1'b0;
                        end
                        gap = ev.now - st.off_t;
                        if (ev.pvalid && gap >= STUCK_DELAY_MS && ev.watts >= lm.stuck_w)
                            hit = FAULT_RELAY_STUCK;
                    end
                end
            OP_RESTART:
            begin
                keep = st.fault;
                st = '0;
                st.fault = keep;
                st.water_miss_t = ev.now;
                st.body_miss_t = ev.now;
                st.off_t = ev.now;
                st.on_t = ev.now;
            end
            OP_EXTERNAL:
                if (ev.ext != FAULT_NONE && ev.ext <= FAULT_MAX_CODE)
                    hit = ev.ext;
            default:
                ;
        endcase
        if (hit != FAULT_NONE && st.fault == FAULT_NONE)
        begin
            st.fault = hit;
            raised = 1'b1;
        end
    endfunction

    function automatic heat_evt_t evt(input logic [2:0] op, input logic [31:0] now,
                                      input logic [15:0] temp, input logic missing,
                                      input logic [15:0] watts, input logic pvalid,
                                      input logic relay, input logic [3:0] ext);
        heat_evt_t ev;
        ev = {op, now, temp, missing, watts, pvalid, relay, ext};
        return ev;
    endfunction

    function automatic limits_t random_limits(input bit crossed);
        limits_t     l;
        logic [15:0] swap;
        l.water_limit   = 16'($urandom_range(400, 2400));
        l.body_limit    = 16'($urandom_range(300, 2000));
        l.water_lost    = $urandom_range(500, 20000);
        l.body_lost     = $urandom_range(500, 20000);
        l.element_delay = $urandom_range(0, 8000);
        l.min_w         = 16'($urandom_range(100, 1200));
        l.max_w         = 16'($urandom_range(800, 4000));
        l.stuck_w       = 16'($urandom_range(20, 600));
        if (crossed && l.min_w <= l.max_w)
        begin
            swap = l.min_w;
            l.min_w = l.max_w + 16'd1;
            l.max_w = swap;
        end
        return l;
    endfunction

    task automatic write_reg(input logic [CFG_INDEX_W-1:0] idx,
                             input logic [CFG_DATA_W-1:0] data);
        @(posedge clk);
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= data;
    endtask

    task automatic load_limits(input limits_t l);
        write_reg(CFG_WATER_FAULT_TEMP, {{16{l.water_limit[15]}}, l.water_limit});
        write_reg(CFG_BODY_FAULT_TEMP,  {{16{l.body_limit[15]}}, l.body_limit});
        write_reg(CFG_WATER_LOST_MS,    l.water_lost);
        write_reg(CFG_BODY_LOST_MS,     l.body_lost);
        write_reg(CFG_ELEMENT_CHECK_MS, l.element_delay);
        write_reg(CFG_MIN_POWER_W,      {16'd0, l.min_w});
        write_reg(CFG_MAX_POWER_W,      {16'd0, l.max_w});
        write_reg(CFG_STUCK_POWER_W,    {16'd0, l.stuck_w});
        @(posedge clk);
        cfg_we <= 1'b0;
        lim = l;
        settings++;
    endtask

    task automatic stage(input heat_evt_t ev);
        logic raised;
        supervise(plan, lim, ev, raised);
        plan_now = ev.now;
        plan_relay = ev.relay;
        event_backlog.push_back(ev);
        staged++;
    endtask

    // Waits until every staged event has produced its result.
    task automatic drain();
        while (seen != staged)
            @(posedge clk);
    endtask

    // Random events that follow the tracked state. Candidates that would latch a
    // fault are redrawn unless their operation is the one allowed to latch.
    task automatic queue_events(input int count, input op_t goal, input bit permit);
        heat_evt_t ev;
        tracker_t  trial;
        logic      raised;
        bit        ok;
        int        n, tries, roll, val;
        for (n = 0; n < count; n++)
        begin
            ok = 1'b0;
            for (tries = 0; tries < 8 && !ok; tries++)
            begin
                roll = $urandom_range(0, 99);
                if (roll < 90)
                    ev.now = plan_now + $urandom_range(0, 400);
                else if (roll < 98)
                    ev.now = plan_now + $urandom_range(400, 20000);
                else
                    ev.now = $urandom;

                roll = $urandom_range(0, 99);
                if (permit && roll < 60)
                    ev.op = goal;
                else
                begin
                    roll = $urandom_range(0, 99);
                    if (roll < 26)
                        ev.op = OP_WATER;
                    else if (roll < 52)
                        ev.op = OP_BODY;
                    else if (roll < 82)
                        ev.op = OP_POWER;
                    else if (roll < 88)
                        ev.op = OP_RESTART;
                    else if (roll < 95)
                        ev.op = OP_EXTERNAL;
                    else
                        ev.op = OP_EXTERNAL + 3'($urandom_range(1, 3));
                end

                if ($urandom_range(0, 99) < 55)
                begin
                    val = (ev.op == OP_BODY) ? int'($signed(lim.body_limit))
                                             : int'($signed(lim.water_limit));
                    val = val + int'($urandom_range(0, 48)) - 40;
                    if (val < -32768)
                        val = -32768;
                    if (val > 32767)
                        val = 32767;
                    ev.temp = 16'(val);
                end
                else
                    ev.temp = 16'($urandom_range(0, 65535));

                roll = $urandom_range(0, 99);
                if (roll < 20)
                    val = int'(lim.min_w);
                else if (roll < 40)
                    val = int'(lim.max_w);
                else if (roll < 60)
                    val = int'(lim.stuck_w);
                else
                    val = int'($urandom_range(0, 65535));
                if (roll < 60)
                begin
                    val = val + int'($urandom_range(0, 20)) - 10;
                    if (val < 0)
                        val = 0;
                    if (val > 65535)
                        val = 65535;
                end
                ev.watts = 16'(val);

                ev.missing = ($urandom_range(0, 99) < 35);
                ev.pvalid  = ($urandom_range(0, 99) < 85);
                ev.relay   = plan_relay ^ ($urandom_range(0, 99) < 12);
                ev.ext     = 4'($urandom_range(0, 15));

                trial = plan;
                supervise(trial, lim, ev, raised);
                ok = !raised || (permit && ev.op == goal);
            end
            if (!ok)
                ev.op = OP_RESTART;
            stage(ev);
        end
    endtask

    always @(posedge clk or negedge rst_n)
    begin : drive
        heat_evt_t ev;
        logic      raised;
        if (!rst_n)
        begin
            in_valid <= 1'b0;
            live = '0;
        end
        else
        begin
            if (in_valid && !in_stall)
            begin
                ev = {operation, now_ms, temp_value, temp_missing,
                      power_watts, power_valid, relay_on, external_code};
                supervise(live, lim, ev, raised);
                fault_reports.push_back({live.fault, raised});
                sent++;
            end
            if (!in_valid || !in_stall)
            begin
                if (event_backlog.size() != 0 &&
                    ((sent >= 700 && sent < 900) || $urandom_range(0, 99) >= IDLE_PCT))
                begin
                    ev = event_backlog.pop_front();
                    in_valid      <= 1'b1;
                    operation     <= ev.op;
                    now_ms        <= ev.now;
                    temp_value    <= ev.temp;
                    temp_missing  <= ev.missing;
                    power_watts   <= ev.watts;
                    power_valid   <= ev.pvalid;
                    relay_on      <= ev.relay;
                    external_code <= ev.ext;
                end
                else
                    in_valid <= 1'b0;
            end
        end
    end

    always @(posedge clk or negedge rst_n)
    begin : watch
        verdict_t want;
        if (!rst_n)
            out_stall <= 1'b0;
        else
        begin
            if (out_valid && !out_stall)
            begin
                seen++;
                if (fault_reports.size() == 0)
                begin
                    $error("result transfer with nothing expected: fault_code %0d new_fault %0b",
                           fault_code, new_fault);
                    fails++;
                end
                else
                begin
                    want = fault_reports.pop_front();
                    if (want.fresh)
                        latched_code = want.code;
                    if (fault_code !== want.code)
                    begin
                        $error("fault_code: expected %0d, actual %0d", want.code, fault_code);
                        fails++;
                    end
                    if (new_fault !== want.fresh)
                    begin
                        $error("new_fault: expected %0b, actual %0b", want.fresh, new_fault);
                        fails++;
                    end
                end
            end
            // One long hold-off lets the block fill up and push back on its input.
            if (hold_left != 0)
            begin
                hold_left--;
                out_stall <= 1'b1;
            end
            else if (!hold_done && seen >= 350)
            begin
                hold_done = 1'b1;
                hold_left = 90;
                out_stall <= 1'b1;
            end
            else
                out_stall <= !(seen >= 700 && seen < 900) &&
                             ($urandom_range(0, 99) < IDLE_PCT);
        end
    end

    always @(posedge clk)
    begin
        cycles <= cycles + 1;
        if (cycles == CYCLE_LIMIT)
        begin
            $error("timeout with %0d of %0d results received", seen, staged);
            $display("CHECKS FAILED");
            $finish;
        end
    end

    initial
    begin : scenario
        limits_t l;
        int      k;
        lim.water_limit   = WATER_FAULT_TEMP_RST;
        lim.body_limit    = BODY_FAULT_TEMP_RST;
        lim.water_lost    = WATER_LOST_MS_RST;
        lim.body_lost     = BODY_LOST_MS_RST;
        lim.element_delay = ELEMENT_CHECK_MS_RST;
        lim.min_w         = MIN_POWER_W_RST;
        lim.max_w         = MAX_POWER_W_RST;
        lim.stuck_w       = STUCK_POWER_W_RST;
        plan = '0;
        plan_now = '0;
        plan_relay = 1'b0;
        repeat (2) @(posedge clk);
        rst_n <= 1'b1;

        // Directed events under the reset thresholds; none of them may latch.
        stage(evt(OP_EXTERNAL, 32'd0, 16'd0, 1'b0, 16'd0, 1'b0, 1'b0, FAULT_NONE));
        for (k = 1; k <= 5; k++)
            stage(evt(OP_EXTERNAL, 32'd10, 16'hFFFF, 1'b1, 16'hFFFF, 1'b1, 1'b1,
                      4'(FAULT_MAX_CODE + k)));
        for (k = 1; k <= 3; k++)
            stage(evt(OP_EXTERNAL + 3'(k), 32'hFFFF_FFFF, 16'h8000, 1'b0, 16'hFFFF,
                      1'b1, 1'b1, FAULT_OVERCURRENT));
        stage(evt(OP_WATER, 32'd100, WATER_FAULT_TEMP_RST - 16'sd1, 1'b0, 16'd0,
                  1'b0, 1'b0, FAULT_NONE));
        stage(evt(OP_WATER, 32'd150, 16'h8000, 1'b0, 16'd0, 1'b0, 1'b0, FAULT_NONE));
        stage(evt(OP_WATER, 32'd200, 16'h7FFF, 1'b1, 16'd0, 1'b0, 1'b0, FAULT_NONE));
        stage(evt(OP_WATER, 32'd200 + WATER_LOST_MS_RST - 32'd1, 16'h7FFF, 1'b1,
                  16'd0, 1'b0, 1'b0, FAULT_NONE));
        stage(evt(OP_BODY, 32'd50000, 16'h7FFF, 1'b1, 16'd0, 1'b0, 1'b0, FAULT_NONE));
        stage(evt(OP_BODY, 32'd50005, BODY_FAULT_TEMP_RST - 16'sd1, 1'b0, 16'd0,
                  1'b0, 1'b0, FAULT_NONE));
        stage(evt(OP_BODY, 32'd50010, 16'd0, 1'b1, 16'd0, 1'b0, 1'b0, FAULT_NONE));
        stage(evt(OP_BODY, 32'd50010 + BODY_LOST_MS_RST - 32'd1, 16'd0, 1'b1, 16'd0,
                  1'b0, 1'b0, FAULT_NONE));
        stage(evt(OP_POWER, 32'd60000, 16'd0, 1'b0, MIN_POWER_W_RST, 1'b1, 1'b1,
                  FAULT_NONE));
        stage(evt(OP_POWER, 32'd64999, 16'd0, 1'b0, 16'hFFFF, 1'b1, 1'b1, FAULT_NONE));
        stage(evt(OP_POWER, 32'd65000, 16'd0, 1'b0, MIN_POWER_W_RST, 1'b1, 1'b1,
                  FAULT_NONE));
        stage(evt(OP_POWER, 32'd65001, 16'd0, 1'b0, MAX_POWER_W_RST, 1'b1, 1'b1,
                  FAULT_NONE));
        stage(evt(OP_POWER, 32'd65002, 16'd0, 1'b0, 16'd0, 1'b0, 1'b1, FAULT_NONE));
        stage(evt(OP_POWER, 32'd66000, 16'd0, 1'b0, 16'hFFFF, 1'b0, 1'b0, FAULT_NONE));
        stage(evt(OP_POWER, 32'd66000 + STUCK_DELAY_MS - 32'd1, 16'd0, 1'b0, 16'hFFFF,
                  1'b1, 1'b0, FAULT_NONE));
        stage(evt(OP_POWER, 32'd69000, 16'd0, 1'b0, STUCK_POWER_W_RST - 16'd1, 1'b1,
                  1'b0, FAULT_NONE));
        // Restart just below the wrap point, then stay inside the limits across it.
        stage(evt(OP_RESTART, 32'hFFFF_FF00, 16'd0, 1'b0, 16'd0, 1'b0, 1'b0, FAULT_NONE));
        stage(evt(OP_WATER, 32'h0000_1000, 16'd0, 1'b1, 16'd0, 1'b0, 1'b0, FAULT_NONE));
        stage(evt(OP_POWER, 32'h0000_0100, 16'd0, 1'b0, 16'hFFFF, 1'b1, 1'b0,
                  FAULT_NONE));
        drain();

        // Upper extremes: almost nothing can trip.
        l.water_limit   = 16'h7FFF;
        l.body_limit    = 16'h7FFF;
        l.water_lost    = 32'hFFFF_FFFF;
        l.body_lost     = 32'hFFFF_FFFF;
        l.element_delay = 32'd0;
        l.min_w         = 16'd0;
        l.max_w         = 16'hFFFF;
        l.stuck_w       = 16'hFFFF;
        load_limits(l);
        queue_events(250, OP_WATER, 1'b0);
        drain();

        load_limits(random_limits(1'b0));
        queue_events(300, OP_WATER, 1'b0);
        drain();

        // Lower extremes: nearly every sample would trip, so only the safe ones pass.
        l.water_limit   = 16'h8000;
        l.body_limit    = 16'h8000;
        l.water_lost    = 32'd0;
        l.body_lost     = 32'd0;
        l.element_delay = 32'hFFFF_FFFF;
        l.min_w         = 16'hFFFF;
        l.max_w         = 16'd0;
        l.stuck_w       = 16'd0;
        load_limits(l);
        queue_events(150, OP_WATER, 1'b0);
        drain();

        // The sender pauses halfway until the block has returned every result.
        load_limits(random_limits(1'b1));
        queue_events(150, OP_WATER, 1'b0);
        drain();
        queue_events(150, OP_WATER, 1'b0);
        drain();

        load_limits(random_limits(1'b0));
        queue_events(250, OP_WATER, 1'b0);
        drain();

        // Closing phase: one operation may latch, then the latched behavior is exercised.
        aim = op_t'($urandom_range(OP_WATER, OP_EXTERNAL));
        load_limits(random_limits($urandom_range(0, 99) < 35));
        queue_events(200, aim, 1'b1);
        drain();

        repeat (10) @(posedge clk);
        if (fault_reports.size() != 0)
        begin
            $error("%0d expected results never arrived", fault_reports.size());
            fails++;
        end
        $display("Sent %0d events under %0d threshold settings and checked %0d results.",
                 sent, settings, seen);
        $display("Closing phase aimed at operation %0d; fault code latched: %0d.",
                 aim, latched_code);
        if (fails == 0)
            $display("ALL CHECKS PASSED");
        else
            $display("CHECKS FAILED");
        $finish;
    end

endmodule
